[rtl/core/met_pkg.sv]
`timescale 1ns / 1ps

package met_pkg;

   // fixed-point format of z and c
   localparam int FRAC_BITS = 28;
   // multiplier operand: |x|, |y| <= 2.0 after the range check
   localparam int MUL_W     = FRAC_BITS + 3;
   localparam int PROD_W    = 2 * MUL_W;

   // configuration registers
   localparam int MAX_ITER_W  = 16;
   localparam int BIAS_W      = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ITER   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_COLOR_BIAS = CSR_INDEX_W'(1);

   localparam logic [MAX_ITER_W-1:0] MAX_ITER_RESET   = MAX_ITER_W'(256);
   localparam logic [BIAS_W-1:0]     COLOR_BIAS_RESET = BIAS_W'(1);

   // controller to datapath
   typedef struct packed {
      logic load;       // capture c, set z = c, clear count
      logic mul_en;     // range check and squares of z
      logic update;     // z = z*z + c, count + 1
      logic load_out;   // capture the result word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_done; // count reached the limit
      logic escape;     // |z| out of range or |z|^2 > 4 for the registered products
   } status_type;

endpackage

[rtl/core/met_csr.sv]
`timescale 1ns / 1ps

module met_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             write_en,
   input  logic [met_pkg::CSR_INDEX_W-1:0]  write_index,
   input  logic [met_pkg::CSR_DATA_W-1:0]   write_data,
   output logic [met_pkg::MAX_ITER_W-1:0]   max_iterations,
   output logic [met_pkg::BIAS_W-1:0]       color_bias
);
   import met_pkg::*;

   logic [MAX_ITER_W-1:0] max_iter_ff;
   logic [BIAS_W-1:0]     bias_ff;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
         bias_ff     <= COLOR_BIAS_RESET;
      end else if (write_en) begin
         unique case (write_index)
            REG_MAX_ITER:   max_iter_ff <= write_data[MAX_ITER_W-1:0];
            REG_COLOR_BIAS: bias_ff     <= write_data[BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   assign max_iterations = max_iter_ff;
   assign color_bias     = bias_ff;

endmodule

[rtl/core/met_ctrl.sv]
`timescale 1ns / 1ps

module met_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  met_pkg::status_type  status,
   output met_pkg::cmd_type     cmd
);
   import met_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      TEST,
      EVAL,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd           = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = TEST;
            end
         end
         TEST: begin
            if (status.count_done) begin
               state_in = FINISH;
            end else begin
               cmd.mul_en = 1'b1;
               state_in   = EVAL;
            end
         end
         EVAL: begin
            if (status.escape) begin
               state_in = FINISH;
            end else begin
               cmd.update = 1'b1;
               state_in   = TEST;
            end
         end
         FINISH: begin
            // wait for the output register to free up
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.load_out  = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

[rtl/core/met_dpath.sv]
`timescale 1ns / 1ps

module met_dpath #(
   parameter int COUNT_WIDTH = 16,
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic signed [COORD_WIDTH-1:0]   c_real,
   input  logic signed [COORD_WIDTH-1:0]   c_imag,
   input  logic [met_pkg::MAX_ITER_W-1:0]  max_iterations,
   input  logic [met_pkg::BIAS_W-1:0]      color_bias,
   input  met_pkg::cmd_type                cmd,
   output met_pkg::status_type             status,
   output logic [COUNT_WIDTH-1:0]          iteration_count,
   output logic [met_pkg::BIAS_W-1:0]      palette_index,
   output logic                            in_set
);
   import met_pkg::*;

   // z holds c plus a product term of up to +-2^31 in Q.28
   localparam int ZW    = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 2;
   localparam int CTR_W = (COUNT_WIDTH > MAX_ITER_W) ? COUNT_WIDTH : MAX_ITER_W;

   localparam logic signed [ZW-1:0]     TWO_Z     = ZW'(64'd2 << FRAC_BITS);
   localparam logic signed [ZW-1:0]     NEG_TWO_Z = -TWO_Z;
   localparam logic signed [PROD_W-1:0] FOUR_SQ   = PROD_W'(64'd4 << (2 * FRAC_BITS));

   logic signed [ZW-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]     cx_ff, cy_ff;
   logic [CTR_W-1:0]         count_ff;
   logic signed [PROD_W-1:0] x2_ff, y2_ff, xy_ff;
   logic signed [PROD_W-1:0] x2_in, y2_in, xy_in;
   logic                     range_esc_ff, range_esc_in;
   logic signed [MUL_W-1:0]  x_op, y_op;
   logic signed [PROD_W-1:0] diff, x_sh, y_sh;
   logic [CTR_W-1:0]         max_ext;

   logic [COUNT_WIDTH-1:0]   count_out_ff;
   logic [BIAS_W-1:0]        palette_ff;
   logic                     in_set_ff;

   assign max_ext = CTR_W'(max_iterations);

   // range check and squares; operands are exact once the check passes
   always_comb begin
      range_esc_in = (x_ff > TWO_Z) || (x_ff < NEG_TWO_Z) ||
                     (y_ff > TWO_Z) || (y_ff < NEG_TWO_Z);
      x_op  = x_ff[MUL_W-1:0];
      y_op  = y_ff[MUL_W-1:0];
      x2_in = x_op * x_op;
      y2_in = y_op * y_op;
      xy_in = x_op * y_op;
   end

   // next z, arithmetic shift floors toward minus infinity
   always_comb begin
      diff = x2_ff - y2_ff;
      x_sh = diff >>> FRAC_BITS;
      y_sh = xy_ff >>> (FRAC_BITS - 1);
      x_in = ZW'(x_sh) + cx_ff;
      y_in = ZW'(y_sh) + cy_ff;
   end

   // iteration registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff    <= ZW'(c_real);
         cy_ff    <= ZW'(c_imag);
         x_ff     <= ZW'(c_real);
         y_ff     <= ZW'(c_imag);
         count_ff <= '0;
      end else if (cmd.update) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         count_ff <= count_ff + CTR_W'(1);
      end
      if (cmd.mul_en) begin
         x2_ff        <= x2_in;
         y2_ff        <= y2_in;
         xy_ff        <= xy_in;
         range_esc_ff <= range_esc_in;
      end
   end

   assign status.count_done = !(count_ff < max_ext);
   assign status.escape     = range_esc_ff || ((x2_ff + y2_ff) > FOUR_SQ);

   // result word
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         count_out_ff <= count_ff[COUNT_WIDTH-1:0];
         palette_ff   <= count_ff[BIAS_W-1:0] + color_bias;
         in_set_ff    <= (count_ff == max_ext);
      end
   end

   assign iteration_count = count_out_ff;
   assign palette_index   = palette_ff;
   assign in_set          = in_set_ff;

endmodule

[rtl/core/mandelbrot_escape_time_core.sv]
`timescale 1ns / 1ps
// Mandelbrot escape-time core, one pixel per request word.
// req channel: c_real and c_imag in signed Q4.28, taken while the core is idle.
// rsp channel: iteration count and palette index in rsp_tdata, in-set flag
// in rsp_tuser; one response word for every request word.
// csr channel: index 0 = max_iterations, index 1 = color_bias; always ready,
// write only while no pixel is in flight.
// Each iteration takes a TEST state for the three 31x31 products of z and
// an EVAL state for the escape compare and the z update. The next request
// is taken in the cycle the response becomes valid.
// The response sits in an output register: a new request is accepted while
// it waits, and the core only holds before loading the next result when the
// receiver stalls rsp_tready.
// Reset (synchronous) empties the core, drops any pending response and
// restores max_iterations = 256 and color_bias = 1.

module mandelbrot_escape_time_core #(
   parameter int COUNT_WIDTH = 16,
   parameter int COORD_WIDTH = 32,
   localparam int REQ_W = ((2 * COORD_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((COUNT_WIDTH + met_pkg::BIAS_W + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // c_real, c_imag
   input  logic [REQ_W-1:0]                req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // iteration_count, palette_index
   output logic [RSP_W-1:0]                rsp_tdata,
   // in_set
   output logic                            rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [met_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [met_pkg::CSR_DATA_W-1:0]  csr_data
);
   import met_pkg::*;

   localparam int CTR_W = (COUNT_WIDTH > MAX_ITER_W) ? COUNT_WIDTH : MAX_ITER_W;

   logic [MAX_ITER_W-1:0]  max_iterations;
   logic [BIAS_W-1:0]      color_bias;
   cmd_type                cmd;
   status_type             status;
   logic [COUNT_WIDTH-1:0] iteration_count;
   logic [BIAS_W-1:0]      palette_index;
   logic                   in_set;

   assign csr_ready = 1'b1;

   // configuration registers
   met_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .write_en       (csr_valid && csr_ready),
      .write_index    (csr_index),
      .write_data     (csr_data),
      .max_iterations (max_iterations),
      .color_bias     (color_bias)
   );

   // sequencing
   met_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // iteration datapath and output register
   met_dpath #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .c_real          (req_tdata[COORD_WIDTH-1:0]),
      .c_imag          (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .max_iterations  (max_iterations),
      .color_bias      (color_bias),
      .cmd             (cmd),
      .status          (status),
      .iteration_count (iteration_count),
      .palette_index   (palette_index),
      .in_set          (in_set)
   );

   assign rsp_tdata = RSP_W'({palette_index, iteration_count});
   assign rsp_tuser = in_set;

`ifndef SYNTHESIS
   logic [CTR_W-1:0] max_ext;
   assign max_ext = CTR_W'(max_iterations);

   // one pixel in flight: an accepted word closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a pixel is in flight");

   // loading the result raises the response valid
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("result loaded but response not valid");

   // in-set results carry the limit as their count
   a_in_set_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (iteration_count == max_ext[COUNT_WIDTH-1:0]))
      else $error("in-set result with a count other than the limit");

   // no iteration step and no result load in the same cycle
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul_en, cmd.update, cmd.load_out}))
      else $error("conflicting datapath commands");
`endif

endmodule
